FILE: sv/lba_pkg.sv
// shared constants, codes and types for the lru block allocator
`timescale 1ns / 1ps
package lba_pkg;

	localparam int NUM_BLOCKS_DEF = 16;

	localparam int MODE_W   = 3;
	localparam int BLOCK_W  = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 8;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_TOUCH    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ALLOC    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ACQUIRE  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RELEASE  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FILLED   = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

	// use count values
	localparam logic signed [COUNT_W-1:0] COUNT_FREE    = 8'sd0;
	localparam logic signed [COUNT_W-1:0] COUNT_FILLED  = 8'sd1;
	localparam logic signed [COUNT_W-1:0] COUNT_WRITING = -8'sd2;
	localparam logic signed [COUNT_W-1:0] COUNT_MAX     = 8'sd127;

	// write enables into the block store
	typedef struct packed {
		logic rank;
		logic cnt;
	} store_we_t;

endpackage

FILE: sv/lba_store.sv
// rank and use count memories with per-entry valid bits standing in for the reset contents
`timescale 1ns / 1ps
module lba_store #(
	parameter int NUM_BLOCKS = lba_pkg::NUM_BLOCKS_DEF,
	parameter int IDXW       = 4,
	parameter int RW         = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rd_en,
	input  logic [IDXW-1:0]                  rd_addr,
	input  lba_pkg::store_we_t               we,
	input  logic [IDXW-1:0]                  rank_waddr,
	input  logic [RW-1:0]                    rank_wdata,
	input  logic [IDXW-1:0]                  cnt_waddr,
	input  logic signed [lba_pkg::COUNT_W-1:0] cnt_wdata,
	output logic [RW-1:0]                    rank_rdata,
	output logic signed [lba_pkg::COUNT_W-1:0] cnt_rdata
);

	logic [RW-1:0]                    rank_mem [NUM_BLOCKS];
	logic signed [lba_pkg::COUNT_W-1:0] cnt_mem [NUM_BLOCKS];

	logic [NUM_BLOCKS-1:0] rank_vld_q;
	logic [NUM_BLOCKS-1:0] cnt_vld_q;

	logic [RW-1:0]                    rank_q;
	logic signed [lba_pkg::COUNT_W-1:0] cnt_q;
	logic [IDXW-1:0]                  addr_q;
	logic                             rank_vld_rd_q;
	logic                             cnt_vld_rd_q;

	always_ff @(posedge clk) begin
		if (we.rank) begin
			rank_mem[rank_waddr] <= rank_wdata;
		end
		if (we.cnt) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (rd_en) begin
			rank_q        <= rank_mem[rd_addr];
			cnt_q         <= cnt_mem[rd_addr];
			addr_q        <= rd_addr;
			rank_vld_rd_q <= rank_vld_q[rd_addr];
			cnt_vld_rd_q  <= cnt_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_vld_q <= '0;
			cnt_vld_q  <= '0;
		end else begin
			if (we.rank) begin
				rank_vld_q[rank_waddr] <= 1'b1;
			end
			if (we.cnt) begin
				cnt_vld_q[cnt_waddr] <= 1'b1;
			end
		end
	end

	// unwritten entry: rank is index+1, count is zero
	assign rank_rdata = rank_vld_rd_q ? rank_q : (RW'(addr_q) + RW'(1));
	assign cnt_rdata  = cnt_vld_rd_q ? cnt_q : lba_pkg::COUNT_FREE;

endmodule

FILE: sv/lba_top_placeholder.sv
// next-rank logic for the recency sweep of the lru block allocator
`timescale 1ns / 1ps
module lba_rank_next #(
	parameter int NUM_BLOCKS = lba_pkg::NUM_BLOCKS_DEF,
	parameter int RW         = 5
) (
	input  logic          hit,
	input  logic [RW-1:0] rank_old,
	output logic [RW-1:0] rank_new
);

	// addressed block goes to rank 1, the others age and saturate at the block count
	always_comb begin
		if (hit) begin
			rank_new = RW'(1);
		end else if (rank_old < RW'(NUM_BLOCKS)) begin
			rank_new = rank_old + RW'(1);
		end else begin
			rank_new = rank_old;
		end
	end

endmodule

FILE: sv/lru_block_allocator_top.sv
// lru block allocator: sequencer around the rank and use count store
//
// channel  direction  handshake             word
// in       to block   in_valid / in_stall   mode, block_index
// out      from block out_valid / out_stall status, result_block, use_count
//
// acquire, mark filled, out-of-range blocks, undefined modes and a touch or release
// of the rank 1 block go from the lookup straight to the result without a sweep.
// touch, release and allocate sweep every entry through the single store read port.
// arst_n clears control state; store entries read as their reset values until written.
// in_stall is high whenever an item is in flight; a result waiting on out_stall
// does not hold off the next word.
`timescale 1ns / 1ps
module lru_block_allocator_top #(
	parameter int NUM_BLOCKS = lba_pkg::NUM_BLOCKS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [lba_pkg::MODE_W-1:0]          mode,
	input  logic [lba_pkg::BLOCK_W-1:0]         block_index,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lba_pkg::STATUS_W-1:0]        status,
	output logic [lba_pkg::BLOCK_W-1:0]         result_block,
	output logic signed [lba_pkg::COUNT_W-1:0]  use_count
);

	localparam int IDXW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int RW   = $clog2(NUM_BLOCKS + 1);
	localparam int SW   = IDXW + 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOOK = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;

	logic [lba_pkg::MODE_W-1:0]   mode_q;
	logic [lba_pkg::BLOCK_W-1:0]  blk_q;
	logic [SW-1:0]                scan_idx_q;
	logic                         scan_vld_s1;
	logic [IDXW-1:0]              scan_idx_s1;
	logic                         found_q;
	logic [IDXW-1:0]              best_idx_q;
	logic [RW-1:0]                best_rank_q;
	logic [lba_pkg::STATUS_W-1:0] res_status_q;
	logic signed [lba_pkg::COUNT_W-1:0] res_count_q;

	logic [lba_pkg::STATUS_W-1:0] status_q;
	logic [lba_pkg::BLOCK_W-1:0]  result_block_q;
	logic signed [lba_pkg::COUNT_W-1:0] use_count_q;
	logic                         out_valid_q;

	logic                         accept;
	logic                         scan_issue;
	logic                         out_load;
	logic                         in_rng;
	logic                         is_alloc;
	logic                         is_touch;
	logic                         alloc_wr;

	logic                         rd_en;
	logic [IDXW-1:0]              rd_addr;
	lba_pkg::store_we_t           we;
	logic [IDXW-1:0]              cnt_waddr;
	logic signed [lba_pkg::COUNT_W-1:0] cnt_wdata;
	logic [RW-1:0]                rank_wdata;
	logic [RW-1:0]                rank_rd;
	logic signed [lba_pkg::COUNT_W-1:0] cnt_rd;

	logic signed [lba_pkg::COUNT_W-1:0] new_cnt;
	logic [lba_pkg::STATUS_W-1:0] new_status;
	logic                         cnt_upd;

	assign accept     = in_valid && (state_q == S_IDLE);
	assign in_stall   = (state_q != S_IDLE);
	assign scan_issue = (state_q == S_SCAN) && (32'(scan_idx_q) < 32'(NUM_BLOCKS));
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign in_rng     = 32'(blk_q) < 32'(NUM_BLOCKS);
	assign is_alloc   = (mode_q == lba_pkg::MODE_ALLOC);
	assign is_touch   = (mode_q == lba_pkg::MODE_TOUCH) || (mode_q == lba_pkg::MODE_RELEASE);
	assign alloc_wr   = out_load && is_alloc && found_q;

	// count update for the addressed block, evaluated while the read data is up
	always_comb begin
		new_cnt    = cnt_rd;
		new_status = lba_pkg::STATUS_DONE;
		cnt_upd    = 1'b0;
		case (mode_q)
			lba_pkg::MODE_ACQUIRE: begin
				cnt_upd = 1'b1;
				if (cnt_rd >= lba_pkg::COUNT_MAX) begin
					new_status = lba_pkg::STATUS_RANGE;
				end else begin
					new_cnt = cnt_rd + 8'sd1;
				end
			end
			lba_pkg::MODE_RELEASE: begin
				cnt_upd = 1'b1;
				if (cnt_rd <= lba_pkg::COUNT_WRITING) begin
					new_status = lba_pkg::STATUS_RANGE;
				end else begin
					new_cnt = cnt_rd - 8'sd1;
				end
			end
			lba_pkg::MODE_FILLED: begin
				cnt_upd = 1'b1;
				new_cnt = lba_pkg::COUNT_FILLED;
			end
			default: begin
				cnt_upd = 1'b0;
			end
		endcase
	end

	// store port control
	assign rd_en   = accept || scan_issue;
	assign rd_addr = accept ? IDXW'(block_index) : scan_idx_q[IDXW-1:0];

	assign we.rank   = scan_vld_s1 && !is_alloc;
	assign we.cnt    = ((state_q == S_LOOK) && in_rng && !is_alloc && cnt_upd) || alloc_wr;
	assign cnt_waddr = alloc_wr ? best_idx_q : IDXW'(blk_q);
	assign cnt_wdata = alloc_wr ? lba_pkg::COUNT_WRITING : new_cnt;

	lba_rank_next #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.RW         (RW)
	) u_rank_next (
		.hit      (scan_idx_s1 == IDXW'(blk_q)),
		.rank_old (rank_rd),
		.rank_new (rank_wdata)
	);

	lba_store #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.IDXW       (IDXW),
		.RW         (RW)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.we         (we),
		.rank_waddr (scan_idx_s1),
		.rank_wdata (rank_wdata),
		.cnt_waddr  (cnt_waddr),
		.cnt_wdata  (cnt_wdata),
		.rank_rdata (rank_rd),
		.cnt_rdata  (cnt_rd)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_vld_s1 <= 1'b0;
			found_q     <= 1'b0;
			scan_idx_q  <= '0;
		end else begin
			scan_vld_s1 <= scan_issue;
			if (scan_issue) begin
				scan_idx_q <= scan_idx_q + SW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					scan_idx_q <= '0;
					found_q    <= 1'b0;
					if (is_alloc) begin
						state_q <= S_SCAN;
					end else if (in_rng && is_touch && (rank_rd != RW'(1))) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					// free block of highest rank, first index wins a tie
					if (scan_vld_s1 && is_alloc && (cnt_rd == lba_pkg::COUNT_FREE) &&
					    (!found_q || (rank_rd > best_rank_q))) begin
						found_q <= 1'b1;
					end
					if (!scan_issue && !scan_vld_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload and scan tracking
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			blk_q  <= block_index;
		end
		if (scan_issue) begin
			scan_idx_s1 <= scan_idx_q[IDXW-1:0];
		end
		if ((state_q == S_LOOK) && !is_alloc) begin
			res_status_q <= in_rng ? new_status : lba_pkg::STATUS_DONE;
			res_count_q  <= in_rng ? new_cnt : lba_pkg::COUNT_FREE;
		end
		if ((state_q == S_SCAN) && scan_vld_s1 && is_alloc &&
		    (cnt_rd == lba_pkg::COUNT_FREE) && (!found_q || (rank_rd > best_rank_q))) begin
			best_idx_q  <= scan_idx_s1;
			best_rank_q <= rank_rd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (is_alloc) begin
				status_q       <= found_q ? lba_pkg::STATUS_DONE : lba_pkg::STATUS_NO_FREE;
				result_block_q <= found_q ? lba_pkg::BLOCK_W'(best_idx_q) : '0;
				use_count_q    <= found_q ? lba_pkg::COUNT_WRITING : lba_pkg::COUNT_FREE;
			end else begin
				status_q       <= res_status_q;
				result_block_q <= blk_q;
				use_count_q    <= res_count_q;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_block = result_block_q;
	assign use_count    = use_count_q;

`ifndef ASSERT_OFF
	a_accept_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_LOOK))
		else $error("accepted word did not start a lookup");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result appeared outside the done state");

	a_rank_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we.rank |-> ((32'(scan_idx_s1) < 32'(NUM_BLOCKS)) && (state_q == S_SCAN)))
		else $error("rank write outside the sweep");

	a_alloc_write_found: assert property (@(posedge clk) disable iff (!arst_n)
		(we.cnt && (state_q == S_DONE)) |-> (found_q && is_alloc))
		else $error("allocate wrote a count without a free block");

	a_no_read_while_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> !rd_en)
		else $error("store read issued while a result is pending");
`endif

endmodule
